FILE: rtl/core/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int DEF_DATA_WIDTH = 32;

  localparam int SMALL_PRIME_MAX = 3;  // 2 and 3 are prime outright
  localparam int FIRST_TRIAL     = 5;  // first wheel candidate
  localparam int WHEEL_STEP      = 6;
  localparam int PAIR_GAP        = 2;  // i and i+2 per wheel turn

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV3,
    ST_DIVI,
    ST_DIVI2
  } tdpt_state_t;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/core/tdpt_div.sv
// ----------------------------------------------------------------------------
// tdpt_div
// Restoring unsigned divider, one quotient bit per cycle, shared by all
// remainder and bound checks of the core.
// ----------------------------------------------------------------------------
module tdpt_div #(
  parameter int DATA_WIDTH = tdpt_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdpt_pkg::div_req_t    req,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output tdpt_pkg::div_sts_t    sts,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH-1:0] dsr_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DATA_WIDTH:0]   rem_sh;
  logic                  fits;

  assign rem_sh = {rem_r, quo_r[DATA_WIDTH-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DATA_WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DATA_WIDTH'(rem_sh - {1'b0, dsr_r}) : rem_sh[DATA_WIDTH-1:0];
      quo_r <= {quo_r[DATA_WIDTH-2:0], fits};
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/trial_division_prime_test_core.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Primality test of a signed integer by 6k +/- 1 trial division on one
// shared iterative divider.
//
//   channel | ports                    | beat taken when
//   --------+--------------------------+------------------------
//   input   | start, in_candidate      | start && !busy
//   result  | out_valid, out_is_prime  | out_valid (one cycle)
//
// Negative, 0..3 and even values: result in the cycle after the beat.
// Otherwise each division runs on the shared divider; an item costs about
// (2 + sqrt(n)/3) divisions. busy is high until the result strobe.
// Synchronous active-low reset; results cannot be stalled.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
  parameter int DATA_WIDTH = tdpt_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_candidate,
  output logic                         out_valid,
  output logic                         out_is_prime
);

  localparam int W = DATA_WIDTH;

  tdpt_pkg::tdpt_state_t state_r, state_nxt;
  logic [W-1:0]          n_r, n_nxt;
  logic [W-1:0]          i_r, i_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_prime_r, out_prime_nxt;

  tdpt_pkg::div_req_t    div_req;
  tdpt_pkg::div_sts_t    div_sts;
  logic [W-1:0]          div_dsr;
  logic [W-1:0]          div_dnd;
  logic [W-1:0]          div_q;
  logic [W-1:0]          div_r;
  logic [W-1:0]          cand_u;

  assign cand_u = in_candidate;

  tdpt_div #(
    .DATA_WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_q),
    .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    out_prime_r <= out_prime_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    div_req.start = 1'b0;
    div_dsr       = i_r;
    div_dnd       = n_r;
    unique case (state_r)
      tdpt_pkg::ST_IDLE: begin
        div_dnd = cand_u;
        div_dsr = W'(tdpt_pkg::SMALL_PRIME_MAX);
        if (start) begin
          n_nxt = cand_u;
          i_nxt = W'(tdpt_pkg::FIRST_TRIAL);
          priority if (cand_u[W-1] || (cand_u < W'(2))) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else if (cand_u <= W'(tdpt_pkg::SMALL_PRIME_MAX)) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
          end else if (!cand_u[0]) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = tdpt_pkg::ST_DIV3;
          end
        end
      end
      tdpt_pkg::ST_DIV3: begin
        if (div_sts.done) begin
          if (div_r == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = tdpt_pkg::ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = tdpt_pkg::ST_DIVI;
          end
        end
      end
      tdpt_pkg::ST_DIVI: begin
        div_dsr = i_r + W'(tdpt_pkg::PAIR_GAP);
        if (div_sts.done) begin
          priority if (i_r > div_q) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
            state_nxt     = tdpt_pkg::ST_IDLE;
          end else if (div_r == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = tdpt_pkg::ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = tdpt_pkg::ST_DIVI2;
          end
        end
      end
      tdpt_pkg::ST_DIVI2: begin
        div_dsr = i_r + W'(tdpt_pkg::WHEEL_STEP);
        if (div_sts.done) begin
          if (div_r == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = tdpt_pkg::ST_IDLE;
          end else begin
            i_nxt         = div_dsr;
            div_req.start = 1'b1;
            state_nxt     = tdpt_pkg::ST_DIVI;
          end
        end
      end
      default: begin
        state_nxt = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != tdpt_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  // accepted beat either starts work or answers on the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted beat neither answered nor started");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_negative_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_candidate[W-1]) |=> (out_valid && !out_is_prime))
    else $error("negative candidate not rejected");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_sts.busy)
    else $error("divider restarted mid-operation");

endmodule

FILE: tb/sv/trial_division_prime_test_core_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_core_test
// Drives signed candidates into the prime test core and checks each result
// strobe, in order, against a local 6k +/- 1 trial division predictor or a
// table flag. A short corner-value table comes first, then random candidates
// that are mostly small, with large values kept cheap (negative, multiple of
// 2 or 3, or a small factor) apart from one full-range prime in the table.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = tdpt_pkg::DEF_DATA_WIDTH;
  localparam int RANDOM_ITEMS = 76;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int DRAIN_CYCLES = 4 * (W + 1);
  localparam int N_DIRECTED   = 24;

  typedef struct packed {
    logic signed [W-1:0] value;
    bit                  fixed;
    bit                  flag;
  } stim_row_t;

  typedef struct packed {
    logic signed [W-1:0] value;
    bit                  flag;
  } prime_expect_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic signed [W-1:0] in_candidate = '0;
  logic                busy;
  logic                out_valid;
  logic                out_is_prime;

  prime_expect_t pending_flags[$];
  stim_row_t     directed_rows[N_DIRECTED];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  bit            no_idle        = 1'b0;

  trial_division_prime_test_core #(
    .DATA_WIDTH(W)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit primality_of(logic signed [W-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    if (cand < 0) return 1'b0;
    n = longint'(cand);
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if ((n % 2) == 0 || (n % 3) == 0) return 1'b0;
    for (d = 5; d <= n / d; d += 6) begin
      if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // one beat: optional idle gap, then hold start until busy is low at an edge
  task automatic send_candidate(input logic signed [W-1:0] cand, input bit flag);
    int gap;
    prime_expect_t entry;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (busy);
    entry.value = cand;
    entry.flag  = flag;
    pending_flags = {pending_flags, entry};
  endtask

  function automatic logic signed [W-1:0] random_candidate();
    int unsigned   pick;
    int unsigned   factor;
    longint        prod;
    pick = $urandom_range(0, 99);
    if (pick < 50) return W'($urandom_range(0, 4095));
    if (pick < 65) return W'($urandom_range(4096, 65535));
    if (pick < 80) return W'($urandom() | 32'h8000_0000);
    if (pick < 90) begin
      prod = longint'($urandom() & 32'h7FFF_FFFF);
      if ($urandom_range(0, 1)) return W'(prod & ~64'd1);
      return W'((prod / 3) * 3);
    end
    case ($urandom_range(0, 5))
      0: factor = 5;
      1: factor = 7;
      2: factor = 11;
      3: factor = 13;
      4: factor = 17;
      default: factor = 19;
    endcase
    prod = longint'(factor) * longint'($urandom_range(1, 32'h7FFF_FFFF / factor));
    return W'(prod);
  endfunction

  always @(posedge clk) begin : result_check
    prime_expect_t head;
    if (rst_n && out_valid) begin
      if (pending_flags.size() == 0) begin
        report_mismatch($sformatf("result %0b with no beat outstanding", out_is_prime));
      end else begin
        head = pending_flags.pop_front();
        if (out_is_prime !== head.flag)
          report_mismatch($sformatf("candidate %0d: is_prime %b, predicted %b",
                                    head.value, out_is_prime, head.flag));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results pending",
               cycle_count, pending_flags.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      '{32'h8000_0000, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0},
      '{32'h8000_0001, 1'b1, 1'b0},
      '{32'd0,         1'b1, 1'b0},
      '{32'd1,         1'b1, 1'b0},
      '{32'd2,         1'b1, 1'b1},
      '{32'd3,         1'b1, 1'b1},
      '{32'd4,         1'b1, 1'b0},
      '{32'd5,         1'b0, 1'b0},
      '{32'd7,         1'b0, 1'b0},
      '{32'd9,         1'b0, 1'b0},
      '{32'd25,        1'b0, 1'b0},
      '{32'd35,        1'b0, 1'b0},
      '{32'd49,        1'b0, 1'b0},
      '{32'd97,        1'b0, 1'b0},
      '{32'd143,       1'b0, 1'b0},
      '{32'd169,       1'b0, 1'b0},
      '{32'd289,       1'b0, 1'b0},
      '{32'd65521,     1'b0, 1'b0},
      '{32'd1000003,   1'b0, 1'b0},
      '{32'h7FFF_FFFE, 1'b0, 1'b0},
      '{32'h7FFF_FFFD, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0},
      '{32'd11,        1'b0, 1'b0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_candidate(directed_rows[k].value,
                     directed_rows[k].fixed ? directed_rows[k].flag
                                            : primality_of(directed_rows[k].value));
    end

    // hold off until the core has drained
    start <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin : random_beats
      logic signed [W-1:0] cand;
      if (k % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      cand = random_candidate();
      send_candidate(cand, primality_of(cand));
    end

    start <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_flags.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_flags.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_div.sv
rtl/core/trial_division_prime_test_core.sv
tb/sv/trial_division_prime_test_core_test.sv
